// ----- rtl/core/sine_segment_calibration_assert.svh -----
// ----------------------------------------------------------------------------
// sine_segment_calibration_assert.svh
// Assertion macros for the sine segment calibration block.
// ----------------------------------------------------------------------------
`ifndef SINE_SEGMENT_CALIBRATION_ASSERT_SVH
`define SINE_SEGMENT_CALIBRATION_ASSERT_SVH

`ifndef SYNTHESIS
// Clocked check, disabled while reset is asserted
`define SSC_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error("ssc assertion failed");
// Clocked check that also holds during reset
`define SSC_ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) else $error("ssc assertion failed");
`else
`define SSC_ASSERT(lbl, prop)
`define SSC_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

// ----- rtl/core/ssc_pkg.sv -----
// ----------------------------------------------------------------------------
// ssc_pkg
// Shared types, constants and tables of the sine segment calibration block.
// ----------------------------------------------------------------------------
package ssc_pkg;

	localparam int MAX_POINTS  = 16;
	localparam int PC_RESET    = 3;
	localparam int CORDIC_STEPS = 30;
	localparam int DIV_NUM_W   = 50;
	localparam int DIV_DEN_W   = 19;

	localparam logic signed [20:0] HALF_TURN    = 21'sd180000;
	localparam logic signed [20:0] QUARTER_TURN = 21'sd90000;
	localparam logic signed [20:0] FULL_TURN    = 21'sd360000;
	localparam logic signed [33:0] CORDIC_X0    = 34'sd652032874;
	localparam logic signed [33:0] SINE_ONE     = 34'sd1073741824;

	// Phase scaling p = (m * 2^32 + 180000) / 360000, split as
	// 11930 * m + (2614 * m + 2812) / 5625, the last by reciprocal multiply
	localparam logic [31:0] PH_BASE_MUL = 32'd11930;
	localparam logic [27:0] PH_REM_MUL  = 28'd2614;
	localparam logic [27:0] PH_BIAS     = 28'd2812;
	localparam logic [28:0] PH_RECIP    = 29'd390937468;
	localparam int          PH_RECIP_SH = 41;

	typedef enum logic [3:0] {
		S_IDLE, S_PREP, S_PMUL, S_PSUM, S_CINIT, S_CORD, S_SINE, S_DECIDE,
		S_SDIV, S_KCALC, S_PROD, S_ICPT, S_OUT
	} state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic capture;
		logic phase_prep;
		logic phase_mul;
		logic phase_sum;
		logic cord_init;
		logic cord_step;
		logic sine_latch;
		logic restart;
		logic slope_div;
		logic k_go;
		logic prod_go;
		logic icpt_go;
		logic out_load;
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic div_done;
		logic cord_last;
		logic restart_req;
		logic beyond;
		logic zero_span;
		logic out_free;
	} sts_t;

	// CORDIC angles in phase units of 2^32 per turn
	function automatic logic [29:0] atan_turn(input logic [4:0] i);
		logic [29:0] r;
		unique case (i)
			5'd0:  r = 30'd536870912;
			5'd1:  r = 30'd316933406;
			5'd2:  r = 30'd167458907;
			5'd3:  r = 30'd85004756;
			5'd4:  r = 30'd42667331;
			5'd5:  r = 30'd21354465;
			5'd6:  r = 30'd10679838;
			5'd7:  r = 30'd5340245;
			5'd8:  r = 30'd2670163;
			5'd9:  r = 30'd1335087;
			5'd10: r = 30'd667544;
			5'd11: r = 30'd333772;
			5'd12: r = 30'd166886;
			5'd13: r = 30'd83443;
			5'd14: r = 30'd41722;
			5'd15: r = 30'd20861;
			5'd16: r = 30'd10430;
			5'd17: r = 30'd5215;
			5'd18: r = 30'd2608;
			5'd19: r = 30'd1304;
			5'd20: r = 30'd652;
			5'd21: r = 30'd326;
			5'd22: r = 30'd163;
			5'd23: r = 30'd81;
			5'd24: r = 30'd41;
			5'd25: r = 30'd20;
			5'd26: r = 30'd10;
			5'd27: r = 30'd5;
			5'd28: r = 30'd3;
			5'd29: r = 30'd1;
			default: r = 30'd0;
		endcase
		return r;
	endfunction

	// Saturate a 64-bit signed value to 48 bits
	function automatic logic [47:0] sat48(input logic signed [63:0] v);
		logic [47:0] r;
		if (v > 64'sh0000_7FFF_FFFF_FFFF) begin
			r = 48'h7FFF_FFFF_FFFF;
		end else if (v < -64'sh0000_8000_0000_0000) begin
			r = 48'h8000_0000_0000;
		end else begin
			r = v[47:0];
		end
		return r;
	endfunction

endpackage

// ----- rtl/core/ssc_div.sv -----
// ----------------------------------------------------------------------------
// ssc_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ssc_div import ssc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [DIV_NUM_W-1:0] num,
	input  logic [DIV_DEN_W-1:0] den,
	output logic                 done,
	output logic [DIV_NUM_W-1:0] quot
);
	localparam int CNT_W = $clog2(DIV_NUM_W);

	logic [DIV_NUM_W-1:0] num_q;
	logic [DIV_DEN_W-1:0] den_q;
	logic [DIV_DEN_W-1:0] rem_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [DIV_DEN_W:0]   trial;
	logic [DIV_DEN_W:0]   diff;
	logic                 qbit;

	// Trial subtract of the shifted remainder
	always_comb begin
		trial = {rem_q, num_q[DIV_NUM_W-1]};
		diff  = trial - {1'b0, den_q};
		qbit  = (trial >= {1'b0, den_q});
	end

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CNT_W'(DIV_NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// Shift registers; quotient bits enter at the bottom of num_q
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[DIV_NUM_W-2:0], qbit};
			rem_q <= qbit ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
		end
	end

	assign done = done_q;
	assign quot = num_q;

endmodule

// ----- rtl/core/ssc_ctrl.sv -----
// ----------------------------------------------------------------------------
// ssc_ctrl
// Sequencer: sine, decision, slope division, intercept and result handoff.
// ----------------------------------------------------------------------------
module ssc_ctrl import ssc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);
	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_PREP;
				end
			end
			S_PREP: begin
				cmd.phase_prep = 1'b1;
				state_d        = S_PMUL;
			end
			S_PMUL: begin
				cmd.phase_mul = 1'b1;
				state_d       = S_PSUM;
			end
			S_PSUM: begin
				cmd.phase_sum = 1'b1;
				state_d       = S_CINIT;
			end
			S_CINIT: begin
				cmd.cord_init = 1'b1;
				state_d       = S_CORD;
			end
			S_CORD: begin
				cmd.cord_step = 1'b1;
				if (sts.cord_last) state_d = S_SINE;
			end
			S_SINE: begin
				cmd.sine_latch = 1'b1;
				state_d        = S_DECIDE;
			end
			S_DECIDE: begin
				priority if (sts.restart_req) begin
					cmd.restart = 1'b1;
					state_d     = S_IDLE;
				end else if (sts.beyond) begin
					state_d = S_IDLE;
				end else if (sts.zero_span) begin
					state_d = S_OUT;
				end else begin
					cmd.slope_div = 1'b1;
					state_d       = S_SDIV;
				end
			end
			S_SDIV: begin
				if (sts.div_done) state_d = S_KCALC;
			end
			S_KCALC: begin
				cmd.k_go = 1'b1;
				state_d  = S_PROD;
			end
			S_PROD: begin
				cmd.prod_go = 1'b1;
				state_d     = S_ICPT;
			end
			S_ICPT: begin
				cmd.icpt_go = 1'b1;
				state_d     = S_OUT;
			end
			S_OUT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

// ----- rtl/core/ssc_dp.sv -----
// ----------------------------------------------------------------------------
// ssc_dp
// Datapath: angle folding, phase scaling, CORDIC sine, slope divider,
// intercept, output.
// ----------------------------------------------------------------------------
`include "sine_segment_calibration_assert.svh"

module ssc_dp import ssc_pkg::*; #(
	parameter int MAX_POINTS = ssc_pkg::MAX_POINTS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               cmd,
	output sts_t               sts,
	input  logic               cfg_we,
	input  logic [6:0]         cfg_data,
	input  logic               first_point,
	input  logic signed [18:0] angle_mdeg,
	input  logic [15:0]        adc_code,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [5:0]         segment_index,
	output logic signed [47:0] slope_k,
	output logic signed [47:0] intercept_a,
	output logic               last_segment,
	output logic               zero_span
);
	// Registers
	logic [6:0]         pcfg_q;
	logic [6:0]         pc_q;
	logic               first_q;
	logic signed [18:0] ang_q;
	logic [15:0]        adc_q;
	logic signed [31:0] prev_sine_q;
	logic [15:0]        prev_adc_q;
	logic [6:0]         seen_q;
	logic [16:0]        ph_mag_q;
	logic               ph_neg_q;
	logic [27:0]        ph_x_q;
	logic [31:0]        ph_base_q;
	logic [31:0]        phase_q;
	logic signed [33:0] x_q, y_q;
	logic signed [32:0] z_q;
	logic [4:0]         i_q;
	logic signed [31:0] s1_q;
	logic signed [47:0] k_q;
	logic signed [63:0] prod_q;
	logic signed [47:0] icpt_q;
	logic               out_valid_q;
	logic [5:0]         seg_out_q;
	logic [47:0]        k_out_q, icpt_out_q;
	logic               last_out_q, zero_out_q;

	// Combinational
	logic [6:0]           pc_eff;
	logic signed [20:0]   a_w, a_f;
	logic                 a_neg;
	logic [16:0]          a_mag;
	logic [27:0]          ph_x_w;
	logic [31:0]          ph_base_w;
	logic [56:0]          ph_prod;
	logic [DIV_NUM_W-1:0] div_num;
	logic [DIV_DEN_W-1:0] div_den;
	logic                 div_done;
	logic [DIV_NUM_W-1:0] quot;
	logic signed [32:0]   z_init;
	logic signed [33:0]   xs, ys;
	logic signed [32:0]   atan_s;
	logic [15:0]          d;
	logic                 d_neg;
	logic [15:0]          d_mag;
	logic signed [32:0]   sdiff;
	logic [31:0]          sdiff_mag;
	logic signed [50:0]   q_s, k_w;
	logic signed [64:0]   prod_w;
	logic signed [63:0]   icpt_w;
	logic [5:0]           seg;

	// Effective point count
	always_comb begin
		priority if (pcfg_q < 7'd2) begin
			pc_eff = 7'd2;
		end else if (pcfg_q > 7'(MAX_POINTS)) begin
			pc_eff = 7'(MAX_POINTS);
		end else begin
			pc_eff = pcfg_q;
		end
	end

	// Angle wrap and fold into a quarter turn
	always_comb begin
		a_w = 21'(ang_q);
		if (a_w > HALF_TURN) begin
			a_w = a_w - FULL_TURN;
		end else if (a_w < -HALF_TURN) begin
			a_w = a_w + FULL_TURN;
		end
		a_f = a_w;
		if (a_w > QUARTER_TURN) begin
			a_f = HALF_TURN - a_w;
		end else if (a_w < -QUARTER_TURN) begin
			a_f = -HALF_TURN - a_w;
		end
		a_neg = a_f[20];
		a_mag = a_neg ? 17'(-a_f) : 17'(a_f);
	end

	// Phase scaling terms, divide by 5625 through the reciprocal
	always_comb begin
		ph_x_w    = 28'(ph_mag_q) * PH_REM_MUL + PH_BIAS;
		ph_base_w = 32'(ph_mag_q) * PH_BASE_MUL;
		ph_prod   = ph_x_q * PH_RECIP;
	end

	// Segment span and sine difference
	always_comb begin
		d         = adc_q - prev_adc_q;
		d_neg     = d[15];
		d_mag     = d_neg ? (16'd0 - d) : d;
		sdiff     = 33'(s1_q) - 33'(prev_sine_q);
		sdiff_mag = sdiff[32] ? 32'(-sdiff) : 32'(sdiff);
	end

	// Slope divider operands
	always_comb begin
		div_num = {4'd0, sdiff_mag, 14'd0};
		div_den = {3'd0, d_mag};
	end

	ssc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.slope_div),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quot   (quot)
	);

	// CORDIC step terms
	always_comb begin
		z_init = ph_neg_q ? -$signed({1'b0, phase_q}) : $signed({1'b0, phase_q});
		xs     = x_q >>> i_q;
		ys     = y_q >>> i_q;
		atan_s = $signed({3'd0, atan_turn(i_q)});
	end

	// Slope sign and intercept
	always_comb begin
		q_s    = $signed({1'b0, quot});
		k_w    = (sdiff[32] != d_neg) ? -q_s : q_s;
		prod_w = k_q * $signed({1'b0, prev_adc_q});
		icpt_w = 64'(prev_sine_q >>> 1) - (prod_q >>> 15);
		seg    = 6'(seen_q - 7'd1);
	end

	// Configuration and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pcfg_q      <= 7'(PC_RESET);
			seen_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) pcfg_q <= cfg_data;
			if (cmd.restart) begin
				seen_q <= 7'd1;
			end else if (cmd.out_load) begin
				seen_q <= seen_q + 7'd1;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_sine_q <= '0;
			prev_adc_q  <= '0;
		end else if (cmd.restart || cmd.out_load) begin
			prev_sine_q <= s1_q;
			prev_adc_q  <= adc_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			first_q <= first_point;
			ang_q   <= angle_mdeg;
			adc_q   <= adc_code;
			pc_q    <= pc_eff;
		end
		if (cmd.phase_prep) begin
			ph_mag_q <= a_mag;
			ph_neg_q <= a_neg;
		end
		if (cmd.phase_mul) begin
			ph_x_q    <= ph_x_w;
			ph_base_q <= ph_base_w;
		end
		if (cmd.phase_sum) phase_q <= ph_base_q + 32'(ph_prod[56:PH_RECIP_SH]);
		if (cmd.cord_init) begin
			x_q <= CORDIC_X0;
			y_q <= '0;
			z_q <= z_init;
			i_q <= '0;
		end else if (cmd.cord_step) begin
			if (!z_q[32]) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - atan_s;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + atan_s;
			end
			i_q <= i_q + 5'd1;
		end
		// Clamp to [-1, 1] in Q1.30
		if (cmd.sine_latch) begin
			priority if (y_q > SINE_ONE) begin
				s1_q <= 32'(SINE_ONE);
			end else if (y_q < -SINE_ONE) begin
				s1_q <= 32'(-SINE_ONE);
			end else begin
				s1_q <= 32'(y_q);
			end
		end
		if (cmd.k_go) k_q <= sat48(64'(k_w));
		if (cmd.prod_go) prod_q <= prod_w[63:0];
		if (cmd.icpt_go) icpt_q <= sat48(icpt_w);
		if (cmd.out_load) begin
			seg_out_q  <= seg;
			last_out_q <= (seen_q == pc_q - 7'd1);
			zero_out_q <= (d == 16'd0);
			k_out_q    <= (d == 16'd0) ? 48'd0 : k_q;
			icpt_out_q <= (d == 16'd0) ? 48'd0 : icpt_q;
		end
	end

	// Status
	always_comb begin
		sts.div_done    = div_done;
		sts.cord_last   = (i_q == 5'(CORDIC_STEPS - 1));
		sts.restart_req = first_q || (seen_q == 7'd0);
		sts.beyond      = (seen_q >= pc_q);
		sts.zero_span   = (d == 16'd0);
		sts.out_free    = !out_valid_q || out_ready;
	end

	assign out_valid     = out_valid_q;
	assign segment_index = seg_out_q;
	assign slope_k       = k_out_q;
	assign intercept_a   = icpt_out_q;
	assign last_segment  = last_out_q;
	assign zero_span     = zero_out_q;

	// Checks
	`SSC_ASSERT(a_load_free, cmd.out_load |-> sts.out_free)
	`SSC_ASSERT(a_restart_one, cmd.restart |=> seen_q == 7'd1)
	`SSC_ASSERT(a_zero_coef, out_valid_q && zero_out_q |-> k_out_q == 48'd0 && icpt_out_q == 48'd0)
	`SSC_ASSERT(a_seen_bound, seen_q <= 7'(MAX_POINTS))

endmodule

// ----- rtl/core/sine_segment_calibration.sv -----
// ----------------------------------------------------------------------------
// sine_segment_calibration
// Piecewise-linear inclinometer calibration: per point, segment slope and
// intercept from CORDIC sines and a serial divider.
// ----------------------------------------------------------------------------
// Channel   Signals                                        Handshake
// input     first_point, angle_mdeg, adc_code              in_valid / in_ready
// output    segment_index, slope_k, intercept_a,
//           last_segment, zero_span                        out_valid / out_ready
// config    cfg_data (point_count)                         cfg_we
//
// A segment request runs from acceptance through angle folding and phase
// scaling, 30 CORDIC iterations, the slope on the one-bit-per-cycle divider,
// and then intercept and handoff before the next acceptance.
// Restart points and points beyond the count stop after the decision; zero spans skip the slope.
// Reset clears the points-seen count and the previous point and sets point_count to 3.
// A finished result waits in the output register; the next request is
// accepted meanwhile and only stalls at its own handoff.
// ----------------------------------------------------------------------------
module sine_segment_calibration import ssc_pkg::*; #(
	parameter int MAX_POINTS = ssc_pkg::MAX_POINTS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [6:0]         cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               first_point,
	input  logic signed [18:0] angle_mdeg,
	input  logic [15:0]        adc_code,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [5:0]         segment_index,
	output logic signed [47:0] slope_k,
	output logic signed [47:0] intercept_a,
	output logic               last_segment,
	output logic               zero_span
);
	cmd_t cmd;
	sts_t sts;

	ssc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ssc_dp #(
		.MAX_POINTS (MAX_POINTS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.cfg_we        (cfg_we),
		.cfg_data      (cfg_data),
		.first_point   (first_point),
		.angle_mdeg    (angle_mdeg),
		.adc_code      (adc_code),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.segment_index (segment_index),
		.slope_k       (slope_k),
		.intercept_a   (intercept_a),
		.last_segment  (last_segment),
		.zero_span     (zero_span)
	);

endmodule
